// ----- design/sma_pkg.sv -----
package sma_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 7;
  localparam int ITER_W  = $clog2(DATA_W);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
  localparam logic [OP_W-1:0] OP_NOP  = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] ST_DIV0  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          req_type;
    logic signed [DATA_W-1:0] push_value;
  } req_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
  } rsp_beat_t;

  // HOLD keeps the entry, DOWN takes the entry above (push),
  // UP takes the entry below (pop).
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DOWN,
    CELL_UP
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
  } cell_ctl_t;

endpackage

// ----- design/stack_machine_arithmetic_top.sv -----
// Stack machine arithmetic unit: push, add, sub, div, mul, nop on a 32-bit stack.
// Push, add, sub, mul, nop and all errors give their beat in the cycle after accept;
// a div gives its beat after the 32 restoring steps in sma_div and a write-back.
// One op at a time: no request is taken while a div is pending or a response is stalled.
// Reset (rst, sync, active high) empties the stack and the response slot;
// stack cells themselves are not cleared.
module stack_machine_arithmetic_top
  import sma_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_beat_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_beat_t rsp
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t state;
  state_t state_next;

  // entry count; cell 0 is the top of stack
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW+6:0]     count_ext;

  logic [DATA_W-1:0] cell_val [STACK_DEPTH];
  cell_ctl_t         ctl_top;
  cell_ctl_t         ctl_rest;
  logic [DATA_W-1:0] new_top;

  logic [DATA_W-1:0] opr_r;     // right operand = top
  logic [DATA_W-1:0] opr_l;     // left operand = next below
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] mul_lo;

  logic              req_fire;
  logic              rsp_free;
  logic              complete;
  logic [STAT_W-1:0] status_next;
  logic [DATA_W-1:0] top_next;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  // ---------------------------------------------------------------
  // Stack: a row of cells, each shifting toward its neighbor
  // ---------------------------------------------------------------
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below;
    cell_ctl_t         ctl;

    if (i == 0) begin : g_top
      assign above = new_top;
      assign ctl   = ctl_top;
    end else begin : g_mid
      assign above = cell_val[i-1];
      assign ctl   = ctl_rest;
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_val[i+1];
    end

    sma_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above),
      .below (below),
      .value (cell_val[i])
    );
  end

  // ---------------------------------------------------------------
  // Divider, multi-cycle unit used by div
  // ---------------------------------------------------------------
  sma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (opr_l),
    .den      (opr_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------
  // Operands and combinational ALU
  // ---------------------------------------------------------------
  assign opr_r  = cell_val[0];
  assign opr_l  = cell_val[1];
  assign mul_lo = opr_l * opr_r;

  always_comb begin
    unique case (req.req_type)
      OP_ADD:  alu_res = opr_l + opr_r;
      OP_SUB:  alu_res = opr_l - opr_r;
      default: alu_res = mul_lo;
    endcase
  end

  // Response slot is free if empty or draining this cycle.
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !rsp_free;
  assign req_fire  = req_valid && !req_stall;

  // ---------------------------------------------------------------
  // Sequencer: decodes a request beat or finishes a pending div
  // ---------------------------------------------------------------
  always_comb begin
    state_next    = state;
    count_next    = count;
    ctl_top.mode  = CELL_HOLD;
    ctl_rest.mode = CELL_HOLD;
    new_top       = req.push_value;
    status_next   = ST_OK;
    complete      = 1'b0;
    div_start     = 1'b0;

    priority if (state == S_DIV) begin
      // quotient replaces the two operands once the slot is free
      if (div_done && rsp_free) begin
        new_top       = div_q;
        ctl_top.mode  = CELL_DOWN;
        ctl_rest.mode = CELL_UP;
        count_next    = count - CW'(1);
        complete      = 1'b1;
        state_next    = S_IDLE;
      end
    end else if (req_fire) begin
      complete = 1'b1;
      priority if (req.req_type == OP_PUSH) begin
        if (count == CW'(STACK_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          ctl_top.mode  = CELL_DOWN;
          ctl_rest.mode = CELL_DOWN;
          count_next    = count + CW'(1);
        end
      end else if (req.req_type == OP_ADD || req.req_type == OP_SUB ||
                   req.req_type == OP_DIV || req.req_type == OP_MUL) begin
        priority if (count < CW'(2)) begin
          status_next = ST_SHORT;
        end else if (req.req_type == OP_DIV && opr_r == '0) begin
          status_next = ST_DIV0;
        end else if (req.req_type == OP_DIV) begin
          div_start  = 1'b1;
          complete   = 1'b0;
          state_next = S_DIV;
        end else begin
          new_top       = alu_res;
          ctl_top.mode  = CELL_DOWN;
          ctl_rest.mode = CELL_UP;
          count_next    = count - CW'(1);
        end
      end else begin
        // nop and unused codes
        status_next = ST_OK;
      end
    end else begin
      // idle, no beat taken: defaults hold
    end
  end

  // top after the op: zero if the stack ends empty, new top when cell 0 loads, else current top
  always_comb begin
    if (count_next == '0) begin
      top_next = '0;
    end else if (ctl_top.mode == CELL_DOWN) begin
      top_next = new_top;
    end else begin
      top_next = cell_val[0];
    end
  end

  assign count_ext = {7'b0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (complete) begin
        rsp_valid       <= 1'b1;
        rsp.status      <= status_next;
        rsp.top_value   <= top_next;
        rsp.stack_depth <= count_ext[DEPTH_W-1:0];
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("entry count exceeds stack depth");

  a_div_start_idle : assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy && state == S_IDLE)
    else $error("divider started while busy");

  a_div_wait : assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !div_done) |=> $stable(count))
    else $error("stack changed during divide");

  a_empty_top : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && count == '0) |-> rsp.top_value == '0)
    else $error("nonzero top on empty stack");
`endif

endmodule

// ----- design/sma_cell.sv -----
module sma_cell
  import sma_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] above,
  input  logic [DATA_W-1:0] below,
  output logic [DATA_W-1:0] value
);

  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      CELL_DOWN: value <= above;
      CELL_UP:   value <= below;
      default:   value <= value;
    endcase
  end

endmodule

// ----- design/sma_div.sv -----
module sma_div
  import sma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              busy,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [ITER_W-1:0] iter;
  logic              neg;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;

  // one restoring step per cycle on magnitudes
  assign rem_sh   = {rem, quo[DATA_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs};
  assign quotient = neg ? (DATA_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      iter <= '0;
      neg  <= num[DATA_W-1] ^ den[DATA_W-1];
      quo  <= num[DATA_W-1] ? (DATA_W'(0) - num) : num;
      dvs  <= den[DATA_W-1] ? (DATA_W'(0) - den) : den;
      rem  <= '0;
    end else if (busy) begin
      if (diff[DATA_W+1]) begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end else begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end
      iter <= iter + ITER_W'(1);
      if (iter == ITER_W'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import sma_pkg::*;

  // Stack size of the unit under test (default of the block).
  localparam int STACK_DEPTH = 64;
  // Worst-case cycles for one op (div: accept, 32 steps, write-back).
  localparam int DIV_CYCLES  = 34;
  // Slowest run is ~1300 ops, each at worst a send gap, a div and a response stall.
  localparam int CYCLE_LIMIT = 600_000;
  localparam int RANDOM_OPS  = 1000;

  // Codes 6 and 7 have no meaning in the unit; they must behave as nop.
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_beat_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_beat_t rsp;

  stack_machine_arithmetic_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow stack: our own copy of the unit's state, advanced once per accepted
  // request beat. Only entries below shadow_count are ever read, so entries
  // never written by a push are never looked at.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned              shadow_count = 0;

  // Status/top/depth snapshots the unit owes us, oldest first.
  rsp_beat_t stack_snapshots [$];

  int mismatches  = 0;
  int cycle_count = 0;
  int op_tally [8];
  int status_tally [4];

  // Idle enables; off gives back-to-back stretches.
  bit req_idle_on = 1'b0;
  bit rsp_idle_on = 1'b0;

  // Applies one op to the shadow stack and returns the snapshot it leaves.
  function automatic rsp_beat_t exec_stack_op(input req_beat_t item);
    rsp_beat_t                snap;
    logic signed [DATA_W-1:0] lhs;
    logic signed [DATA_W-1:0] rhs;
    logic signed [DATA_W-1:0] res;
    longint                   quot;
    bit                       done;
    snap.status = ST_OK;
    case (item.req_type)
      OP_PUSH: begin
        if (shadow_count >= STACK_DEPTH) begin
          snap.status = ST_FULL;
        end else begin
          shadow_stack[shadow_count] = item.push_value;
          shadow_count++;
        end
      end
      OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
        // depth check wins over the zero-divisor check
        if (shadow_count < 2) begin
          snap.status = ST_SHORT;
        end else begin
          rhs  = shadow_stack[shadow_count - 1];
          lhs  = shadow_stack[shadow_count - 2];
          res  = '0;
          done = 1'b1;
          case (item.req_type)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default: begin
              if (rhs == 0) begin
                done        = 1'b0;
                snap.status = ST_DIV0;
              end else begin
                // 64-bit divide truncates toward zero; MIN / -1 wraps to MIN
                quot = longint'(lhs) / longint'(rhs);
                res  = quot[DATA_W-1:0];
              end
            end
          endcase
          if (done) begin
            shadow_stack[shadow_count - 2] = res;
            shadow_count--;
          end
        end
      end
      default: ; // nop and the two spare codes
    endcase
    snap.top_value   = (shadow_count > 0) ? shadow_stack[shadow_count - 1] : '0;
    snap.stack_depth = DEPTH_W'(shadow_count);
    return snap;
  endfunction

  function automatic int pick_gap(input bit enabled);
    return enabled ? int'($urandom_range(0, 14)) : 0;
  endfunction

  // Operand mix: zeros, +-1 and the extremes show up far more often than
  // plain random words would give them.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      2:       return $urandom_range(0, 1) ? INT_MIN : INT_MAX;
      3, 4:    return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // Sends one request beat. Called right after the previous accept (or after
  // reset), so valid is only lowered when a gap is drawn; back-to-back beats
  // just swap the payload.
  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
    req_beat_t item;
    int        gap;
    item.req_type   = op;
    item.push_value = value;
    gap = pick_gap(req_idle_on);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    // accepted at this edge
    stack_snapshots.push_back(exec_stack_op(item));
    op_tally[op]++;
  endtask

  // Response side: hold stall for a drawn number of cycles, then take one beat.
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = pick_gap(rsp_idle_on);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
    end
  end

  // Checker: every accepted response beat against the oldest snapshot.
  always @(posedge clk) begin
    rsp_beat_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      status_tally[rsp.status]++;
      if (stack_snapshots.size() == 0) begin
        $error("response beat with nothing outstanding: status=%0d top=%0d depth=%0d",
               rsp.status, rsp.top_value, rsp.stack_depth);
        mismatches++;
      end else begin
        want = stack_snapshots.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatches++;
        end
        if (rsp.top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, rsp.top_value);
          mismatches++;
        end
        if (rsp.stack_depth !== want.stack_depth) begin
          $error("stack_depth: expected %0d, got %0d", want.stack_depth, rsp.stack_depth);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every op but push on an empty stack: binaries report too-short, the rest are nops.
  task automatic test_empty_stack();
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    send_op(OP_ADD, $urandom);
    send_op(OP_SUB, $urandom);
    send_op(OP_DIV, '0);
    send_op(OP_MUL, $urandom);
    send_op(OP_NOP, '1);
    send_op(OP_SPARE6, $urandom);
    send_op(OP_SPARE7, $urandom);
  endtask

  // Corners of the arithmetic, back to back on both sides.
  task automatic test_arith_corners();
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    send_op(OP_PUSH, '0);
    send_op(OP_DIV, $urandom);   // one entry with a zero top: too short, not div0
    send_op(OP_ADD, $urandom);
    send_op(OP_PUSH, INT_MIN);
    send_op(OP_PUSH, -32'sd1);
    send_op(OP_DIV, $urandom);   // MIN / -1 wraps to MIN
    send_op(OP_PUSH, '0);
    send_op(OP_DIV, $urandom);   // divide by zero, stack untouched
    send_op(OP_SUB, $urandom);   // MIN - 0
    send_op(OP_PUSH, INT_MAX);
    send_op(OP_ADD, $urandom);   // MIN + MAX = -1
    send_op(OP_PUSH, INT_MAX);
    send_op(OP_MUL, $urandom);   // -1 * MAX = -MAX, does not wrap
    send_op(OP_PUSH, -32'sd2);
    send_op(OP_DIV, $urandom);   // negative / negative, truncated
    send_op(OP_PUSH, -32'sd7);
    send_op(OP_PUSH, 32'sd2);
    send_op(OP_DIV, $urandom);   // -7 / 2 = -3
    send_op(OP_SUB, $urandom);
    send_op(OP_NOP, '0);
  endtask

  // Fill to the top, overflow, then drain to a single entry and run too-short ops.
  task automatic test_fill_and_overflow();
    logic [OP_W-1:0] binary_ops [4] = '{OP_ADD, OP_SUB, OP_DIV, OP_MUL};
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b0;
    while (shadow_count < STACK_DEPTH) send_op(OP_PUSH, pick_value());
    repeat (3) send_op(OP_PUSH, pick_value());
    send_op(OP_NOP, $urandom);
    send_op(binary_ops[$urandom_range(0, 3)], $urandom);
    send_op(OP_PUSH, pick_value());
    send_op(OP_PUSH, pick_value());
    rsp_idle_on = 1'b1;
    while (shadow_count >= 2) send_op(binary_ops[$urandom_range(0, 3)], $urandom);
    repeat (3) send_op(binary_ops[$urandom_range(0, 3)], $urandom);
  endtask

  // Segments with their own push bias and idle modes: low bias keeps the
  // stack shallow and hits too-short often, high bias walks it into full.
  task automatic test_random_mix();
    logic [OP_W-1:0] binary_ops [4] = '{OP_ADD, OP_SUB, OP_DIV, OP_MUL};
    logic [OP_W-1:0] idle_ops [3]   = '{OP_NOP, OP_SPARE6, OP_SPARE7};
    int push_pct;
    int pick;
    int counted;
    counted = 0;
    while (counted < RANDOM_OPS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 25;
        1:       push_pct = 50;
        default: push_pct = 72;
      endcase
      req_idle_on = ($urandom_range(0, 2) != 0);
      rsp_idle_on = ($urandom_range(0, 2) != 0);
      repeat (100) begin
        pick = $urandom_range(0, 99);
        if (pick < push_pct) begin
          send_op(OP_PUSH, pick_value());
          counted++;
        end else if (pick < 95) begin
          send_op(binary_ops[$urandom_range(0, 3)], $urandom);
          counted++;
        end else begin
          send_op(idle_ops[$urandom_range(0, 2)], $urandom);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_stack();
    test_arith_corners();
    test_fill_and_overflow();
    test_random_mix();

    // last beat was just accepted; nothing more to offer
    req_valid <= 1'b0;
    while (stack_snapshots.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (2 * DIV_CYCLES) @(posedge clk);

    $display("Ran %0d ops: push %0d, add %0d, sub %0d, div %0d, mul %0d, nop/spare %0d.",
             op_tally.sum(), op_tally[OP_PUSH], op_tally[OP_ADD], op_tally[OP_SUB],
             op_tally[OP_DIV], op_tally[OP_MUL],
             op_tally[OP_NOP] + op_tally[OP_SPARE6] + op_tally[OP_SPARE7]);
    $display("Responses: ok %0d, too short %0d, div by zero %0d, stack full %0d.",
             status_tally[ST_OK], status_tally[ST_SHORT], status_tally[ST_DIV0],
             status_tally[ST_FULL]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
